FILE: design/flba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_pkg
// Shared types and codes of the free-list block allocator.
// ----------------------------------------------------------------------------
package flba_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RND,
        S_A_CHK,
        S_A_TAKE,
        S_A_SPL,
        S_A_SPL2,
        S_A_APP,
        S_A_APP1,
        S_A_APP2,
        S_A_APP3,
        S_F_IDX,
        S_F_CHK,
        S_F_NX,
        S_F_W,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        ST_REUSED  = 2'd0,
        ST_EXTENDED = 2'd1,
        ST_NO_MEM  = 2'd2,
        ST_FREED   = 2'd3
    } t_status;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_NEXT  = 2'd1;
    localparam logic [1:0] POL_BEST  = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam int  PADDR_W        = 3;
    localparam logic [PADDR_W-1:0] REG_FIT_POLICY = 3'd0;

endpackage

FILE: design/flba_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_req_if
// Request channel: allocate or free transaction.
// ----------------------------------------------------------------------------
interface flba_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] req_size;
    logic [14:0] data_addr;

    modport source (output valid, kind, req_size, data_addr, input ready);
    modport sink   (input valid, kind, req_size, data_addr, output ready);
endinterface

FILE: design/flba_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_rsp_if
// Response channel: status and data offset of one transaction.
// ----------------------------------------------------------------------------
interface flba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [14:0] block_addr;

    modport source (output valid, status, block_addr, input ready);
    modport sink   (input valid, status, block_addr, output ready);
endinterface

FILE: design/free_list_block_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_block_allocator_top
// Heap allocator keeping an address-ordered chain of block headers.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries allocate (kind 0, req_size) and free (kind 1, data_addr)
//   transactions; o_rsp returns one status / block_addr per transaction.
//   fit_policy (APB, address 0) selects first, next or best fit; write it
//   only while the block is idle.
//   Until the response is valid, an allocate rounds the size, walks the
//   chain one header per cycle, then takes a block and may split it, or
//   appends a block (no link step on an empty heap); a free checks the
//   header and, on a match, may absorb a free successor and writes back.
//   The block is ready again in the cycle after the response is loaded, so
//   one transaction is in work at a time; header reads set the search time.
//   A finished response sits in an output register, so a new request is
//   taken while the response waits; if the receiver stalls and a second
//   response is ready, the block holds in its done state until it drains.
//   Reset (synchronous, active low) empties the heap and clears the resume
//   pointer; the header memory needs no clearing pass.
// ----------------------------------------------------------------------------
module free_list_block_allocator_top #(
    parameter int HEAP_BYTES   = 32768,
    parameter int HEADER_BYTES = 24,
    parameter int WORD_BYTES   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    flba_req_if.sink                       i_req,
    flba_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [flba_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    localparam int AW    = $clog2(HEAP_BYTES + 1);
    localparam int DW    = (AW > 17) ? AW : 17;
    localparam int DEPTH = HEAP_BYTES / WORD_BYTES + 1;
    localparam int IW    = $clog2(DEPTH);

    typedef struct packed {
        logic          valid;
        logic          used;
        logic          has_next;
        logic [AW-1:0] start;
        logic [AW-1:0] size;
        logic [IW-1:0] nxt;
    } t_hdr;

    localparam int HW = $bits(t_hdr);

    flba_pkg::t_state r_state, n_state;

    logic [14:0]   r_daddr;
    logic          r_ok, n_ok;
    logic [DW-1:0] r_size, n_size;
    logic [IW-1:0] r_cur, n_cur;
    logic [IW-1:0] r_start, n_start;
    logic [IW-1:0] r_bi, n_bi;
    t_hdr          r_bh, n_bh;
    logic          r_have, n_have;
    logic [IW-1:0] r_aux, n_aux;
    logic [1:0]    r_status, n_status;
    logic [14:0]   r_addr, n_addr;

    logic          r_heap_empty, n_heap_empty;
    logic [IW-1:0] r_last, n_last;
    logic [AW-1:0] r_heap_top, n_heap_top;
    logic          r_res_valid, n_res_valid;
    logic [IW-1:0] r_resume, n_resume;
    logic [1:0]    r_policy;

    logic          r_ovalid, n_ovalid;
    logic [1:0]    r_ostatus;
    logic [14:0]   r_oaddr;
    logic          load_out;

    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_hdr          ram_wdata;
    logic [HW-1:0] ram_rdata;
    t_hdr          h;
    logic [DW-1:0] div_op, div_q;

    logic          fits, upd;
    logic [IW-1:0] step_idx;
    logic [DW-1:0] leftover;
    logic [DW-1:0] split_start;
    logic [DW:0]   need_top;
    logic [DW-1:0] free_st;

    flba_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_hdr_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    flba_div #(.DW(DW), .WORD_BYTES(WORD_BYTES)) u_div (
        .i_clk(i_clk),
        .i_op (div_op),
        .o_quo(div_q)
    );

    assign h = t_hdr'(ram_rdata);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == flba_pkg::REG_FIT_POLICY) ? {30'd0, r_policy} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= flba_pkg::POL_FIRST;
        end else if (psel && penable && pwrite && paddr == flba_pkg::REG_FIT_POLICY) begin
            r_policy <= pwdata[1:0];
        end
    end

    assign i_req.ready      = i_rst_n && (r_state == flba_pkg::S_IDLE);
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_ostatus;
    assign o_rsp.block_addr = r_oaddr;

    assign fits        = !h.used && (DW'(h.size) >= r_size);
    assign upd         = fits && (!r_have || h.size < r_bh.size);
    assign step_idx    = h.has_next ? h.nxt : '0;
    assign leftover    = DW'(r_bh.size) - r_size;
    assign split_start = DW'(r_bh.start) + DW'(HEADER_BYTES) + r_size;
    assign need_top    = (DW+1)'(r_heap_top) + (DW+1)'(HEADER_BYTES) + (DW+1)'(r_size);
    assign free_st     = DW'(r_daddr) - DW'(HEADER_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= flba_pkg::S_IDLE;
            r_heap_empty <= 1'b1;
            r_last       <= '0;
            r_heap_top   <= '0;
            r_res_valid  <= 1'b0;
            r_resume     <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_heap_empty <= n_heap_empty;
            r_last       <= n_last;
            r_heap_top   <= n_heap_top;
            r_res_valid  <= n_res_valid;
            r_resume     <= n_resume;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_daddr <= i_req.data_addr;
        end
        if (load_out) begin
            r_ostatus <= r_status;
            r_oaddr   <= r_addr;
        end
        r_ok     <= n_ok;
        r_size   <= n_size;
        r_cur    <= n_cur;
        r_start  <= n_start;
        r_bi     <= n_bi;
        r_bh     <= n_bh;
        r_have   <= n_have;
        r_aux    <= n_aux;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    always_comb begin
        n_state      = r_state;
        n_ok         = r_ok;
        n_size       = r_size;
        n_cur        = r_cur;
        n_start      = r_start;
        n_bi         = r_bi;
        n_bh         = r_bh;
        n_have       = r_have;
        n_aux        = r_aux;
        n_status     = r_status;
        n_addr       = r_addr;
        n_heap_empty = r_heap_empty;
        n_last       = r_last;
        n_heap_top   = r_heap_top;
        n_res_valid  = r_res_valid;
        n_resume     = r_resume;
        load_out     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = r_bi;
        ram_wdata    = r_bh;
        ram_raddr    = r_cur;
        div_op       = '0;

        unique case (r_state)
            flba_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.kind == flba_pkg::KIND_FREE) begin
                        div_op  = DW'(i_req.data_addr) - DW'(HEADER_BYTES);
                        n_ok    = (DW'(i_req.data_addr) >= DW'(HEADER_BYTES)) &&
                                  (DW'(i_req.data_addr) - DW'(HEADER_BYTES) < DW'(r_heap_top));
                        n_state = flba_pkg::S_F_IDX;
                    end else begin
                        div_op  = DW'(i_req.req_size) + DW'(WORD_BYTES - 1);
                        n_state = flba_pkg::S_A_RND;
                    end
                end
            end
            flba_pkg::S_A_RND: begin
                n_size = DW'(div_q * DW'(WORD_BYTES));
                n_have = 1'b0;
                if (r_policy == flba_pkg::POL_NEXT && r_res_valid) begin
                    n_cur   = r_resume;
                    n_start = r_resume;
                end else begin
                    n_cur   = '0;
                    n_start = '0;
                end
                ram_raddr = n_cur;
                n_state   = r_heap_empty ? flba_pkg::S_A_APP : flba_pkg::S_A_CHK;
            end
            flba_pkg::S_A_CHK: begin
                ram_raddr = step_idx;
                priority if (r_policy == flba_pkg::POL_NEXT) begin
                    if (fits) begin
                        n_bi        = r_cur;
                        n_bh        = h;
                        n_resume    = r_cur;
                        n_res_valid = 1'b1;
                        n_state     = flba_pkg::S_A_TAKE;
                    end else if (step_idx == r_start) begin
                        n_state = flba_pkg::S_A_APP;
                    end else begin
                        n_cur = step_idx;
                    end
                end else if (r_policy == flba_pkg::POL_BEST) begin
                    if (upd) begin
                        n_bi   = r_cur;
                        n_bh   = h;
                        n_have = 1'b1;
                    end
                    if (h.has_next) begin
                        n_cur = step_idx;
                    end else begin
                        n_state = (r_have || upd) ? flba_pkg::S_A_TAKE : flba_pkg::S_A_APP;
                    end
                end else begin
                    if (fits) begin
                        n_bi    = r_cur;
                        n_bh    = h;
                        n_state = flba_pkg::S_A_TAKE;
                    end else if (h.has_next) begin
                        n_cur = step_idx;
                    end else begin
                        n_state = flba_pkg::S_A_APP;
                    end
                end
            end
            flba_pkg::S_A_TAKE: begin
                n_status = flba_pkg::ST_REUSED;
                n_addr   = 15'(DW'(r_bh.start) + DW'(HEADER_BYTES));
                if (leftover >= DW'(HEADER_BYTES + WORD_BYTES)) begin
                    div_op  = split_start;
                    n_state = flba_pkg::S_A_SPL;
                end else begin
                    ram_we         = 1'b1;
                    ram_wdata.used = 1'b1;
                    n_state        = flba_pkg::S_DONE;
                end
            end
            flba_pkg::S_A_SPL: begin
                // remainder block behind the taken one
                n_aux              = IW'(div_q);
                ram_we             = 1'b1;
                ram_waddr          = IW'(div_q);
                ram_wdata.valid    = 1'b1;
                ram_wdata.used     = 1'b0;
                ram_wdata.has_next = r_bh.has_next;
                ram_wdata.start    = AW'(split_start);
                ram_wdata.size     = AW'(leftover - DW'(HEADER_BYTES));
                ram_wdata.nxt      = r_bh.nxt;
                n_state            = flba_pkg::S_A_SPL2;
            end
            flba_pkg::S_A_SPL2: begin
                ram_we             = 1'b1;
                ram_wdata.used     = 1'b1;
                ram_wdata.has_next = 1'b1;
                ram_wdata.size     = AW'(r_size);
                ram_wdata.nxt      = r_aux;
                if (r_last == r_bi) begin
                    n_last = r_aux;
                end
                n_state = flba_pkg::S_DONE;
            end
            flba_pkg::S_A_APP: begin
                if (need_top > (DW+1)'(HEAP_BYTES)) begin
                    n_status = flba_pkg::ST_NO_MEM;
                    n_addr   = '0;
                    n_state  = flba_pkg::S_DONE;
                end else begin
                    div_op  = DW'(r_heap_top);
                    n_state = flba_pkg::S_A_APP1;
                end
            end
            flba_pkg::S_A_APP1: begin
                n_aux     = IW'(div_q);
                ram_raddr = r_last;
                n_state   = r_heap_empty ? flba_pkg::S_A_APP3 : flba_pkg::S_A_APP2;
            end
            flba_pkg::S_A_APP2: begin
                // link the old last block to the new one
                ram_we             = 1'b1;
                ram_waddr          = r_last;
                ram_wdata          = h;
                ram_wdata.has_next = 1'b1;
                ram_wdata.nxt      = r_aux;
                n_state            = flba_pkg::S_A_APP3;
            end
            flba_pkg::S_A_APP3: begin
                ram_we             = 1'b1;
                ram_waddr          = r_aux;
                ram_wdata.valid    = 1'b1;
                ram_wdata.used     = 1'b1;
                ram_wdata.has_next = 1'b0;
                ram_wdata.start    = r_heap_top;
                ram_wdata.size     = AW'(r_size);
                ram_wdata.nxt      = '0;
                n_last             = r_aux;
                n_heap_empty       = 1'b0;
                n_status           = flba_pkg::ST_EXTENDED;
                n_addr             = 15'(DW'(r_heap_top) + DW'(HEADER_BYTES));
                n_heap_top         = AW'(need_top);
                n_state            = flba_pkg::S_DONE;
            end
            flba_pkg::S_F_IDX: begin
                n_status  = flba_pkg::ST_FREED;
                n_addr    = '0;
                n_bi      = IW'(div_q);
                ram_raddr = IW'(div_q);
                n_state   = r_ok ? flba_pkg::S_F_CHK : flba_pkg::S_DONE;
            end
            flba_pkg::S_F_CHK: begin
                ram_raddr = h.nxt;
                if (!(h.valid && h.start == AW'(free_st))) begin
                    n_state = flba_pkg::S_DONE;
                end else begin
                    n_bh    = h;
                    n_state = h.has_next ? flba_pkg::S_F_NX : flba_pkg::S_F_W;
                end
            end
            flba_pkg::S_F_NX: begin
                if (!h.used) begin
                    // absorb the free successor
                    ram_we          = 1'b1;
                    ram_waddr       = r_bh.nxt;
                    ram_wdata       = h;
                    ram_wdata.valid = 1'b0;
                    n_bh.size       = AW'(DW'(r_bh.size) + DW'(HEADER_BYTES) + DW'(h.size));
                    n_bh.nxt        = h.nxt;
                    n_bh.has_next   = h.has_next;
                    if (r_last == r_bh.nxt) begin
                        n_last = r_bi;
                    end
                    if (r_res_valid && r_resume == r_bh.nxt) begin
                        n_resume = r_bi;
                    end
                end
                n_state = flba_pkg::S_F_W;
            end
            flba_pkg::S_F_W: begin
                ram_we         = 1'b1;
                ram_wdata.used = 1'b0;
                n_state        = flba_pkg::S_DONE;
            end
            flba_pkg::S_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = flba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = flba_pkg::S_IDLE;
            end
        endcase

        n_ovalid = (r_ovalid && !o_rsp.ready) || load_out;
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != flba_pkg::S_IDLE))
        else $error("accepted transaction did not start work");

    a_top_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DW+1)'(r_heap_top) <= (DW+1)'(HEAP_BYTES))
        else $error("heap top beyond heap end");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heap_empty |-> (r_heap_top == '0))
        else $error("empty heap with nonzero top");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_ovalid ##1 r_ovalid) |-> ($past(r_state) == flba_pkg::S_DONE))
        else $error("response raised outside done state");
`endif
endmodule

FILE: design/flba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module flba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/flba_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flba_div
// Shared divide-by-word-size unit: reciprocal multiply, registered product.
// ----------------------------------------------------------------------------
module flba_div #(
    parameter int DW         = 17,
    parameter int WORD_BYTES = 8
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_op,
    output logic [DW-1:0] o_quo
);
    localparam int SH    = DW + 3;
    localparam int PW    = DW + SH + 1;
    localparam int RECIP = ((2 ** SH) + WORD_BYTES - 1) / WORD_BYTES;

    logic [PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_op) * PW'(RECIP);
    end

    assign o_quo = r_prod[SH +: DW];
endmodule
